@@ rtl/semiring_bellman_ford_engine_top_macros.svh @@
// Assertion macros for the semiring Bellman-Ford engine checker.
// Each macro expands to one labelled concurrent assertion clocked on the rising edge.
`ifndef SEMIRING_BELLMAN_FORD_ENGINE_TOP_MACROS_SVH
`define SEMIRING_BELLMAN_FORD_ENGINE_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SBFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbfe assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SBFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbfe assertion failed");

`endif

@@ rtl/sbfe_pkg.sv @@
// Shared types and constants of the semiring Bellman-Ford engine.
// Used by the top level and by its port checker; depends on nothing else.
package sbfe_pkg;

  localparam int MAX_NODES_DEF  = 64;
  localparam int MAX_EDGES_DEF  = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int FRAC_BITS      = 16;

  // Input word operations.
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_SOLVE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Path modes.
  localparam logic [1:0] MODE_SHORTEST   = 2'd0;
  localparam logic [1:0] MODE_RELIABLE   = 2'd1;
  localparam logic [1:0] MODE_BOTTLENECK = 2'd2;
  localparam logic [1:0] MODE_FUZZY      = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_PATH_MODE   = 2'd0;
  localparam logic [1:0] REG_NODE_COUNT  = 2'd1;
  localparam logic [1:0] REG_SOURCE_NODE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_EDGE_RD,
    ST_NODE_RD,
    ST_CALC,
    ST_MUL,
    ST_MSAT,
    ST_WRITE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

@@ rtl/semiring_bellman_ford_engine_top.sv @@
// Semiring Bellman-Ford engine: edge store, node value store and relaxation sequencer.
// Depends on sbfe_pkg.
//
// Appends, clears and ignored words leave the block idle, so it is ready again
// in the next cycle. A solve word holds off intake until its last node word has been
// loaded into the output register: it writes the start values node by node (n is the
// effective node count), then makes n-1 passes over the E stored edges, each edge going
// through edge read, node reads, candidate and write back; the write back is skipped when
// an endpoint is out of range or, in shortest and most reliable modes, the tail value is
// infinite. In most reliable mode multiply and saturate steps come before the write back;
// there the Q16.16 product is built from four half-width partial products on one
// multiplier. Emission then reads each node and loads it into the output register,
// waiting while the consumer holds off. One edge is in flight at a time, so a write
// back always lands before the next read of the node store.
module semiring_bellman_ford_engine_top #(
  parameter int MAX_NODES  = sbfe_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES  = sbfe_pkg::MAX_EDGES_DEF,
  parameter int VALUE_BITS = sbfe_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [5:0]         in_edge_from,
  input  logic [5:0]         in_edge_to,
  input  logic signed [31:0] in_edge_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_node_index,
  output logic signed [31:0] out_node_value,
  output logic               out_value_infinite,
  output logic               out_edges_dropped,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);
  import sbfe_pkg::*;

  localparam int VB  = VALUE_BITS;
  localparam int IW  = $clog2(MAX_NODES);
  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int EDW = 12 + VB;
  localparam int H   = (VB + 1) / 2;
  localparam int AW  = 2 * VB;
  localparam int SW  = $clog2(AW + 1);

  localparam logic signed [VB-1:0] VMAX  = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN  = {1'b1, {(VB-1){1'b0}}};
  localparam logic signed [VB-1:0] ONE_V =
    (VB > FRAC_BITS + 1) ? VB'(64'd1 << FRAC_BITS) : VMAX;
  localparam logic signed [63:0] VMAX64 = 64'(VMAX);
  localparam logic signed [63:0] VMIN64 = 64'(VMIN);
  localparam logic signed [63:0] OMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] OMIN64 = -64'sd2147483648;
  localparam logic [AW-1:0] LIM_W = AW'(1) << (VB - 1);
  localparam logic [NW-1:0] N_MAX = NW'(MAX_NODES);
  localparam logic [ETW-1:0] E_MAX = ETW'(MAX_EDGES);

  // Storage.
  logic [EDW-1:0] edge_mem [MAX_EDGES];
  logic [VB:0]    node_mem [MAX_NODES];

  // Control registers.
  state_t          state_r, state_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [6:0]      ncount_r, ncount_nxt;
  logic [5:0]      src_r, src_nxt;
  logic [ETW-1:0]  total_r, total_nxt;
  logic            ovf_r, ovf_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [NW-1:0]   idx_r, idx_nxt;
  logic [NW-1:0]   pass_r, pass_nxt;
  logic [ETW-1:0]  eidx_r, eidx_nxt;
  logic [2:0]      step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic                 skip_r, skip_nxt;
  logic signed [VB-1:0] cand_r, cand_nxt;
  logic [VB-1:0]        ma_r, ma_nxt;
  logic [VB-1:0]        mb_r, mb_nxt;
  logic                 neg_r, neg_nxt;
  logic [2*H-1:0]       prod_r, prod_nxt;
  logic [SW-1:0]        shift_r, shift_nxt;
  logic [AW-1:0]        acc_r, acc_nxt;
  logic [5:0]           out_index_r, out_index_nxt;
  logic signed [31:0]   out_value_r, out_value_nxt;
  logic                 out_inf_r, out_inf_nxt;
  logic                 out_drop_r, out_drop_nxt;
  logic                 out_last_r, out_last_nxt;

  // Memory read data.
  logic [EDW-1:0] edge_q_r;
  logic [VB:0]    na_q_r;
  logic [VB:0]    nb_q_r;

  // Memory port controls.
  logic           edge_we, edge_re;
  logic [EDW-1:0] edge_wdata;
  logic           node_we;
  logic [IW-1:0]  node_waddr;
  logic [VB:0]    node_wdata;
  logic           na_re, nb_re;
  logic [IW-1:0]  na_addr, nb_addr;

  // Combinational helpers.
  logic signed [63:0]   w_wide;
  logic signed [VB-1:0] w_sat;
  logic [NW-1:0]        n_eff;
  logic [5:0]           e_from, e_to;
  logic signed [VB-1:0] e_w;
  logic                 u_inf, v_inf;
  logic signed [VB-1:0] u_val, v_val;
  logic signed [VB:0]   sum_c;
  logic signed [VB-1:0] sum_sat;
  logic [VB-1:0]        u_mag, w_mag;
  logic [H-1:0]         a_sel, b_sel;
  logic [2*H-1:0]       prod_c;
  logic [AW-1:0]        sh_c;
  logic [VB-1:0]        sh_lo;
  logic                 sh_big;
  logic signed [63:0]   emit_wide;
  logic [ETW-1:0]       eidx_inc;
  logic [NW-1:0]        pass_inc, idx_inc;
  logic                 is_src;
  logic                 advance;

  assign in_ready           = (state_r == ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_node_index     = out_index_r;
  assign out_node_value     = out_value_r;
  assign out_value_infinite = out_inf_r;
  assign out_edges_dropped  = out_drop_r;
  assign out_last           = out_last_r;

  // Incoming weights are clamped to the value range once, at append time.
  assign w_wide     = 64'(in_edge_weight);
  assign w_sat      = (w_wide > VMAX64) ? VMAX :
                      (w_wide < VMIN64) ? VMIN : w_wide[VB-1:0];
  assign edge_wdata = {in_edge_from, in_edge_to, w_sat};

  assign n_eff = (ncount_r == 7'd0)           ? NW'(1) :
                 (ncount_r > 7'(MAX_NODES))   ? N_MAX  : NW'(ncount_r);

  assign e_from = edge_q_r[EDW-1 -: 6];
  assign e_to   = edge_q_r[VB+5 -: 6];
  assign e_w    = edge_q_r[VB-1:0];
  assign u_inf  = na_q_r[VB];
  assign u_val  = na_q_r[VB-1:0];
  assign v_inf  = nb_q_r[VB];
  assign v_val  = nb_q_r[VB-1:0];

  assign sum_c   = {u_val[VB-1], u_val} + {e_w[VB-1], e_w};
  assign sum_sat = (sum_c[VB] != sum_c[VB-1]) ? (sum_c[VB] ? VMIN : VMAX) : sum_c[VB-1:0];

  assign u_mag = u_val[VB-1] ? (~na_q_r[VB-1:0] + VB'(1)) : na_q_r[VB-1:0];
  assign w_mag = e_w[VB-1]   ? (~edge_q_r[VB-1:0] + VB'(1)) : edge_q_r[VB-1:0];

  // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
  assign a_sel  = step_r[1] ? H'(ma_r[VB-1:H]) : ma_r[H-1:0];
  assign b_sel  = step_r[0] ? H'(mb_r[VB-1:H]) : mb_r[H-1:0];
  assign prod_c = a_sel * b_sel;

  assign sh_c   = acc_r >> FRAC_BITS;
  assign sh_lo  = sh_c[VB-1:0];
  assign sh_big = (sh_c >= LIM_W);

  assign emit_wide = 64'(signed'(na_q_r[VB-1:0]));

  assign eidx_inc = eidx_r + ETW'(1);
  assign pass_inc = pass_r + NW'(1);
  assign idx_inc  = idx_r + NW'(1);
  assign is_src   = (7'(idx_r) == {1'b0, src_r});

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    ncount_nxt    = ncount_r;
    src_nxt       = src_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    pass_nxt      = pass_r;
    eidx_nxt      = eidx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    skip_nxt      = skip_r;
    cand_nxt      = cand_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    shift_nxt     = shift_r;
    acc_nxt       = acc_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_inf_nxt   = out_inf_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;
    edge_we       = 1'b0;
    edge_re       = 1'b0;
    node_we       = 1'b0;
    node_waddr    = '0;
    node_wdata    = '0;
    na_re         = 1'b0;
    nb_re         = 1'b0;
    na_addr       = '0;
    nb_addr       = '0;
    advance       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATH_MODE:   mode_nxt   = cfg_data[1:0];
        REG_NODE_COUNT:  ncount_nxt = cfg_data;
        REG_SOURCE_NODE: src_nxt    = cfg_data[5:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            FUNC_APPEND: begin
              if (total_r == E_MAX) begin
                ovf_nxt = 1'b1;
              end else begin
                edge_we   = 1'b1;
                total_nxt = total_r + ETW'(1);
              end
            end
            FUNC_SOLVE: begin
              n_nxt     = n_eff;
              idx_nxt   = '0;
              state_nxt = ST_INIT;
            end
            FUNC_CLEAR: begin
              total_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
      end

      ST_INIT: begin
        node_we    = 1'b1;
        node_waddr = idx_r[IW-1:0];
        if (is_src) begin
          node_wdata = {mode_r == MODE_BOTTLENECK,
                        ((mode_r == MODE_RELIABLE) || (mode_r == MODE_FUZZY)) ?
                        ONE_V : VB'(0)};
        end else begin
          node_wdata = {mode_r == MODE_SHORTEST, VB'(0)};
        end
        idx_nxt = idx_inc;
        if (idx_inc == n_r) begin
          idx_nxt  = '0;
          pass_nxt = NW'(1);
          eidx_nxt = '0;
          // A single node or an empty store needs no relaxation pass.
          if ((n_r == NW'(1)) || (total_r == '0)) begin
            state_nxt = ST_EMIT_RD;
          end else begin
            state_nxt = ST_EDGE_RD;
          end
        end
      end

      ST_EDGE_RD: begin
        edge_re   = 1'b1;
        state_nxt = ST_NODE_RD;
      end

      ST_NODE_RD: begin
        skip_nxt  = ({1'b0, e_from} >= 7'(n_r)) || ({1'b0, e_to} >= 7'(n_r));
        na_re     = 1'b1;
        nb_re     = 1'b1;
        na_addr   = e_from[IW-1:0];
        nb_addr   = e_to[IW-1:0];
        state_nxt = ST_CALC;
      end

      ST_CALC: begin
        if (skip_r) begin
          advance = 1'b1;
        end else begin
          case (mode_r)
            MODE_SHORTEST: begin
              if (u_inf) begin
                advance = 1'b1;
              end else begin
                cand_nxt  = sum_sat;
                state_nxt = ST_WRITE;
              end
            end
            MODE_RELIABLE: begin
              if (u_inf) begin
                advance = 1'b1;
              end else begin
                ma_nxt    = u_mag;
                mb_nxt    = w_mag;
                neg_nxt   = u_val[VB-1] ^ e_w[VB-1];
                step_nxt  = '0;
                state_nxt = ST_MUL;
              end
            end
            default: begin
              cand_nxt  = u_inf ? e_w : ((u_val < e_w) ? u_val : e_w);
              state_nxt = ST_WRITE;
            end
          endcase
        end
      end

      ST_MUL: begin
        if (step_r != 3'd4) begin
          prod_nxt  = prod_c;
          shift_nxt = (step_r[1] && step_r[0]) ? SW'(2 * H) :
                      (step_r[1] || step_r[0]) ? SW'(H) : '0;
        end
        if (step_r == 3'd0) begin
          acc_nxt = '0;
        end else begin
          acc_nxt = acc_r + (AW'(prod_r) << shift_r);
        end
        if (step_r == 3'd4) begin
          state_nxt = ST_MSAT;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end

      ST_MSAT: begin
        if (!neg_r) begin
          cand_nxt = sh_big ? VMAX : sh_lo;
        end else begin
          cand_nxt = sh_big ? VMIN : (~sh_lo + VB'(1));
        end
        state_nxt = ST_WRITE;
      end

      ST_WRITE: begin
        node_waddr = e_to[IW-1:0];
        node_wdata = {1'b0, cand_r};
        if (mode_r == MODE_SHORTEST) begin
          node_we = v_inf || (cand_r < v_val);
        end else begin
          node_we = !v_inf && (cand_r > v_val);
        end
        advance = 1'b1;
      end

      ST_EMIT_RD: begin
        // Issue the read only when the output register will be free next cycle.
        if (!out_valid_r || out_ready) begin
          na_re     = 1'b1;
          na_addr   = idx_r[IW-1:0];
          state_nxt = ST_EMIT_LD;
        end
      end

      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_index_nxt = 6'(idx_r);
        out_inf_nxt   = u_inf;
        out_drop_nxt  = ovf_r;
        out_last_nxt  = (idx_inc == n_r);
        if (u_inf) begin
          out_value_nxt = '0;
        end else if (emit_wide > OMAX64) begin
          out_value_nxt = OMAX64[31:0];
        end else if (emit_wide < OMIN64) begin
          out_value_nxt = OMIN64[31:0];
        end else begin
          out_value_nxt = emit_wide[31:0];
        end
        idx_nxt = idx_inc;
        if (idx_inc == n_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (advance) begin
      if (eidx_inc == total_r) begin
        eidx_nxt = '0;
        if (pass_inc == n_r) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          pass_nxt  = pass_inc;
          state_nxt = ST_EDGE_RD;
        end
      end else begin
        eidx_nxt  = eidx_inc;
        state_nxt = ST_EDGE_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_SHORTEST;
      ncount_r    <= 7'd1;
      src_r       <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      n_r         <= NW'(1);
      idx_r       <= '0;
      pass_r      <= '0;
      eidx_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      ncount_r    <= ncount_nxt;
      src_r       <= src_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      pass_r      <= pass_nxt;
      eidx_r      <= eidx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    skip_r      <= skip_nxt;
    cand_r      <= cand_nxt;
    ma_r        <= ma_nxt;
    mb_r        <= mb_nxt;
    neg_r       <= neg_nxt;
    prod_r      <= prod_nxt;
    shift_r     <= shift_nxt;
    acc_r       <= acc_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_inf_r   <= out_inf_nxt;
    out_drop_r  <= out_drop_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Edge store: one write port for appends, one registered read port for the passes.
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[total_r[EW-1:0]] <= edge_wdata;
    end
    if (edge_re) begin
      edge_q_r <= edge_mem[eidx_r[EW-1:0]];
    end
  end

  // Node value store: infinity flag above the value, two registered read ports.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (na_re) begin
      na_q_r <= node_mem[na_addr];
    end
    if (nb_re) begin
      nb_q_r <= node_mem[nb_addr];
    end
  end

endmodule

@@ rtl/sbfe_checker.sv @@
// Port-level checker for the semiring Bellman-Ford engine, bound to the top level.
// Depends on sbfe_pkg and semiring_bellman_ford_engine_top_macros.svh.
`include "semiring_bellman_ford_engine_top_macros.svh"

module sbfe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_func,
  input logic               out_valid,
  input logic               out_ready,
  input logic [5:0]         out_node_index,
  input logic signed [31:0] out_node_value,
  input logic               out_value_infinite,
  input logic               out_last
);
  import sbfe_pkg::*;

  // A stalled result word keeps its node and value.
  `SBFE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_node_index) && $stable(out_node_value))

  // A solve word that is taken closes intake.
  `SBFE_ASSERT_NXT(a_solve_busy, clk, rst_n, in_valid && in_ready && (in_func == FUNC_SOLVE), !in_ready)

  // Nothing follows the final word of a run straight away.
  `SBFE_ASSERT_NXT(a_last_gap, clk, rst_n, out_valid && out_ready && out_last, !out_valid)

  // An infinite value is reported as zero.
  `SBFE_ASSERT_IMP(a_inf_zero, clk, rst_n, out_valid && out_value_infinite, out_node_value == 32'sd0)

endmodule

bind semiring_bellman_ford_engine_top sbfe_checker u_sbfe_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for semiring_bellman_ford_engine_top: edge loading, all four
// path modes, store overflow, back-pressure and random traffic against an in-bench predictor.
// Depends on sbfe_pkg and the engine top level only.
`timescale 1ns / 1ps

module tb_top;
  import sbfe_pkg::*;

  localparam int N_MAX = MAX_NODES_DEF;
  localparam int E_MAX = MAX_EDGES_DEF;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS = 320;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -VAL_MAX - 1;
  localparam longint Q16_ONE = 64'sd65536;

  typedef struct {
    logic [5:0]         index;
    logic signed [31:0] value;
    logic               infinite;
    logic               dropped;
    logic               last;
  } node_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic [5:0]         in_edge_from;
  logic [5:0]         in_edge_to;
  logic signed [31:0] in_edge_weight;
  logic               out_valid;
  logic               out_ready;
  logic [5:0]         out_node_index;
  logic signed [31:0] out_node_value;
  logic               out_value_infinite;
  logic               out_edges_dropped;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [6:0]         cfg_data;

  // Predictor copy of the configuration and of the engine state.
  logic [1:0]         mode_q;
  logic [6:0]         count_q;
  logic [5:0]         source_q;
  logic [5:0]         tail_mem [E_MAX];
  logic [5:0]         head_mem [E_MAX];
  logic signed [31:0] weight_mem [E_MAX];
  int                 stored_edges;
  bit                 dropped_q;
  longint             node_val [N_MAX];
  bit                 node_inf [N_MAX];

  node_word_t node_words_due [$];
  int         mismatch_count;
  int         in_idle_pct;
  int         out_idle_pct;
  int         stall_request;
  int         stall_left;

  semiring_bellman_ford_engine_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_edge_from       (in_edge_from),
    .in_edge_to         (in_edge_to),
    .in_edge_weight     (in_edge_weight),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_node_index     (out_node_index),
    .out_node_value     (out_node_value),
    .out_value_infinite (out_value_infinite),
    .out_edges_dropped  (out_edges_dropped),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #300000000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_value(input longint x);
    if (x > VAL_MAX) return VAL_MAX;
    if (x < VAL_MIN) return VAL_MIN;
    return x;
  endfunction

  // Q16.16 product: magnitude truncated toward zero, then saturated.
  function automatic longint fixed_mul(input longint a, input longint b);
    bit               neg;
    longint unsigned  ma;
    longint unsigned  mb;
    longint unsigned  shifted;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    shifted = (ma * mb) >> 16;
    if (!neg) return (shifted > 64'd2147483647) ? VAL_MAX : longint'(shifted);
    return (shifted > 64'd2147483647) ? VAL_MIN : -longint'(shifted);
  endfunction

  function automatic int effective_nodes();
    if (count_q == 0) return 1;
    if (count_q > N_MAX) return N_MAX;
    return int'(count_q);
  endfunction

  function automatic void relax_graph();
    int         n;
    int         u;
    int         v;
    longint     w;
    longint     cand;
    node_word_t word;
    n = effective_nodes();
    for (int i = 0; i < n; i++) begin
      node_val[i] = 0;
      node_inf[i] = (mode_q == MODE_SHORTEST);
    end
    if (source_q < n) begin
      node_inf[source_q] = (mode_q == MODE_BOTTLENECK);
      node_val[source_q] = (mode_q == MODE_RELIABLE || mode_q == MODE_FUZZY) ? Q16_ONE : 0;
    end
    for (int p = 1; p < n; p++) begin
      for (int e = 0; e < stored_edges; e++) begin
        u = int'(tail_mem[e]);
        v = int'(head_mem[e]);
        w = longint'(weight_mem[e]);
        if (u >= n || v >= n) continue;
        case (mode_q)
          MODE_SHORTEST: begin
            if (!node_inf[u]) begin
              cand = clamp_value(node_val[u] + w);
              if (node_inf[v] || cand < node_val[v]) begin
                node_val[v] = cand;
                node_inf[v] = 1'b0;
              end
            end
          end
          MODE_RELIABLE: begin
            if (!node_inf[u]) begin
              cand = fixed_mul(node_val[u], w);
              if (!node_inf[v] && cand > node_val[v]) node_val[v] = cand;
            end
          end
          default: begin
            cand = node_inf[u] ? w : ((node_val[u] < w) ? node_val[u] : w);
            if (!node_inf[v] && cand > node_val[v]) node_val[v] = cand;
          end
        endcase
      end
    end
    for (int i = 0; i < n; i++) begin
      word.index    = i[5:0];
      word.value    = node_inf[i] ? 32'sd0 : node_val[i][31:0];
      word.infinite = node_inf[i];
      word.dropped  = dropped_q;
      word.last     = (i == n - 1);
      node_words_due.insert(node_words_due.size(), word);
    end
  endfunction

  function automatic void apply_word(input logic [1:0] func, input logic [5:0] from_node,
                                     input logic [5:0] to_node,
                                     input logic signed [31:0] weight);
    case (func)
      FUNC_APPEND: begin
        if (stored_edges >= E_MAX) begin
          dropped_q = 1'b1;
        end else begin
          tail_mem[stored_edges]   = from_node;
          head_mem[stored_edges]   = to_node;
          weight_mem[stored_edges] = weight;
          stored_edges++;
        end
      end
      FUNC_CLEAR: begin
        stored_edges = 0;
        dropped_q = 1'b0;
      end
      FUNC_SOLVE: relax_graph();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    node_word_t due;
    if (rst_n && out_valid && out_ready) begin
      if (node_words_due.size() == 0) begin
        report_mismatch("unexpected node word, index", longint'(out_node_index), -1);
      end else begin
        due = node_words_due.pop_front();
        if (out_node_index !== due.index)
          report_mismatch("node_index", longint'(out_node_index), longint'(due.index));
        if (out_node_value !== due.value)
          report_mismatch("node_value", longint'(out_node_value), longint'(due.value));
        if (out_value_infinite !== due.infinite)
          report_mismatch("value_infinite", longint'(out_value_infinite),
                          longint'(due.infinite));
        if (out_edges_dropped !== due.dropped)
          report_mismatch("edges_dropped", longint'(out_edges_dropped),
                          longint'(due.dropped));
        if (out_last !== due.last)
          report_mismatch("last", longint'(out_last), longint'(due.last));
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_word(input logic [1:0] func, input logic [5:0] from_node,
                           input logic [5:0] to_node, input logic signed [31:0] weight);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_edge_from   <= from_node;
    in_edge_to     <= to_node;
    in_edge_weight <= weight;
    do @(posedge clk); while (!in_ready);
    apply_word(func, from_node, to_node, weight);
  endtask

  task automatic send_control(input logic [1:0] func);
    send_word(func, 6'($urandom_range(63)), 6'($urandom_range(63)), $urandom);
  endtask

  // Lowers valid and waits until every predicted node word has come out.
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (node_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATH_MODE:   mode_q = data[1:0];
      REG_NODE_COUNT:  count_q = data;
      REG_SOURCE_NODE: source_q = data[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] mode, input logic [6:0] count,
                           input logic [5:0] src);
    write_reg(REG_PATH_MODE, {5'd0, mode});
    write_reg(REG_NODE_COUNT, count);
    write_reg(REG_SOURCE_NODE, {1'b0, src});
  endtask

  function automatic logic signed [31:0] pick_weight();
    case ($urandom_range(8))
      0, 1: return $urandom;
      2: return 32'sh7FFF_FFFF;
      3: return 32'sh8000_0000;
      4: return 32'sh0001_0000;
      5: return 32'sd0;
      6: return $urandom_range(65536);
      default: return $signed($urandom_range(262143)) - 32'sd131072;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    // Reset configuration: one node, shortest path, source 0.
    send_control(FUNC_SOLVE);
    wait_results_done();
  endtask

  task automatic test_shortest_extremes();
    configure(MODE_SHORTEST, 7'd4, 6'd0);
    send_control(FUNC_CLEAR);
    send_word(FUNC_APPEND, 6'd0, 6'd1, 32'sh7FFF_FFFF);
    send_word(FUNC_APPEND, 6'd1, 6'd2, 32'sh7FFF_FFFF);
    send_word(FUNC_APPEND, 6'd0, 6'd3, 32'sh8000_0000);
    send_word(FUNC_APPEND, 6'd3, 6'd2, -32'sd1);
    send_word(FUNC_APPEND, 6'd63, 6'd63, 32'sd0);
    send_control(FUNC_UNUSED);
    send_control(FUNC_SOLVE);
    wait_results_done();
  endtask

  task automatic test_reliable_paths();
    // A node count above the node limit acts as the limit itself.
    configure(MODE_RELIABLE, 7'd127, 6'd63);
    send_control(FUNC_CLEAR);
    send_word(FUNC_APPEND, 6'd63, 6'd0, 32'sh7FFF_FFFF);
    send_word(FUNC_APPEND, 6'd0, 6'd1, 32'sh8000_0000);
    send_word(FUNC_APPEND, 6'd63, 6'd2, 32'sh0000_8000);
    send_word(FUNC_APPEND, 6'd2, 6'd3, -32'sh0000_8000);
    send_control(FUNC_SOLVE);
    wait_results_done();
  endtask

  task automatic test_max_min_modes();
    configure(MODE_BOTTLENECK, 7'd3, 6'd1);
    send_control(FUNC_CLEAR);
    send_word(FUNC_APPEND, 6'd1, 6'd0, 32'sh0003_0000);
    send_word(FUNC_APPEND, 6'd0, 6'd2, 32'sh7FFF_FFFF);
    send_word(FUNC_APPEND, 6'd2, 6'd1, 32'sh0005_0000);
    send_control(FUNC_SOLVE);
    wait_results_done();
    write_reg(REG_PATH_MODE, {5'd0, MODE_FUZZY});
    send_control(FUNC_SOLVE);
    wait_results_done();
    // A zero node count acts as one; the source then lies outside the graph.
    configure(MODE_FUZZY, 7'd0, 6'd40);
    send_control(FUNC_SOLVE);
    wait_results_done();
    write_reg(REG_NODE_COUNT, 7'd3);
    send_control(FUNC_SOLVE);
    wait_results_done();
  endtask

  task automatic test_store_overflow();
    configure(MODE_SHORTEST, 7'd2, 6'd0);
    send_control(FUNC_CLEAR);
    repeat (E_MAX + 2) send_word(FUNC_APPEND, 6'($urandom_range(1)), 6'($urandom_range(1)),
                                 pick_weight());
    send_control(FUNC_SOLVE);
    send_control(FUNC_CLEAR);
    send_control(FUNC_SOLVE);
    wait_results_done();
  endtask

  task automatic test_output_backpressure();
    configure(MODE_SHORTEST, 7'd8, 6'd0);
    // The receiver holds off long enough for the engine to fill and refuse words.
    stall_request = 2000;
    send_control(FUNC_CLEAR);
    repeat (4) send_word(FUNC_APPEND, 6'($urandom_range(7)), 6'($urandom_range(7)),
                         pick_weight());
    send_control(FUNC_SOLVE);
    repeat (2) send_word(FUNC_APPEND, 6'($urandom_range(7)), 6'($urandom_range(7)),
                         pick_weight());
    send_control(FUNC_SOLVE);
    wait_results_done();
  endtask

  task automatic pick_random_config();
    logic [6:0] count;
    int         eff;
    case ($urandom_range(15))
      0: count = 7'd64;
      1: count = 7'd0;
      2: count = 7'd127;
      3: count = 7'd1;
      4, 5: count = 7'($urandom_range(16, 9));
      default: count = 7'($urandom_range(8, 2));
    endcase
    eff = (count == 0) ? 1 : (count > N_MAX) ? N_MAX : int'(count);
    configure(2'($urandom_range(3)), count,
              6'(($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(eff - 1)));
  endtask

  task automatic test_random_traffic(input int items);
    int sent;
    int seq;
    int eff;
    sent = 0;
    seq = 0;
    while (sent < items) begin
      if (seq % 3 == 0) begin
        wait_results_done();
        pick_random_config();
      end
      seq++;
      eff = effective_nodes();
      if (stored_edges > 20 || $urandom_range(3) == 0) begin
        send_control(FUNC_CLEAR);
        sent++;
      end
      repeat ($urandom_range(8)) begin
        if ($urandom_range(9) < 8)
          send_word(FUNC_APPEND, 6'($urandom_range(eff - 1)), 6'($urandom_range(eff - 1)),
                    pick_weight());
        else
          send_word(FUNC_APPEND, 6'($urandom_range(63)), 6'($urandom_range(63)),
                    pick_weight());
        sent++;
      end
      if ($urandom_range(5) == 0) send_control(FUNC_UNUSED);
      if ($urandom_range(9) != 0) begin
        send_control(FUNC_SOLVE);
        sent++;
      end
    end
    wait_results_done();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_APPEND;
    in_edge_from   = '0;
    in_edge_to     = '0;
    in_edge_weight = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_PATH_MODE;
    cfg_data       = '0;
    mode_q         = MODE_SHORTEST;
    count_q        = 7'd1;
    source_q       = '0;
    stored_edges   = 0;
    dropped_q      = 1'b0;
    mismatch_count = 0;
    stall_request  = 0;
    stall_left     = 0;
    in_idle_pct    = 30;
    out_idle_pct   = 50;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_shortest_extremes();
    test_reliable_paths();
    test_max_min_modes();
    test_store_overflow();
    test_output_backpressure();
    test_random_traffic(RANDOM_ITEMS / 3);
    in_idle_pct  = 50;
    out_idle_pct = 30;
    test_random_traffic(RANDOM_ITEMS / 3);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && node_words_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sbfe_pkg.sv
rtl/semiring_bellman_ford_engine_top.sv
rtl/sbfe_checker.sv
dv/tb_top.sv
